@@ src/eikonal_cell_update_assert.svh @@
// Assertion macros shared by the eikonal cell update RTL.
// Depends on nothing; the including module must have clock and reset.
`ifndef EIKONAL_CELL_UPDATE_ASSERT_SVH
`define EIKONAL_CELL_UPDATE_ASSERT_SVH

// Implication in the same cycle.
`define EKU_ASSERT_NOW(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("eikonal cell update: same-cycle check failed");

// Implication in the next cycle.
`define EKU_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("eikonal cell update: next-cycle check failed");

`endif

@@ src/eku_pkg.sv @@
// Shared types and constants of the eikonal cell update pipeline.
// No dependencies.
package eku_pkg;

   localparam int DIST_BITS = 32;
   localparam int SUM3_BITS = DIST_BITS + 2;
   localparam int RAD_BITS  = 2 * SUM3_BITS;
   localparam int ROOT_BITS = SUM3_BITS;
   localparam int TOT_BITS  = SUM3_BITS + 2;
   localparam int HALF_BITS = TOT_BITS / 2;

   // Division by three as a multiplication by the rounded-up reciprocal.
   localparam int          DIV3_SHIFT = 38;
   localparam int          DIV3_BITS  = 37;
   localparam logic [36:0] DIV3_MUL   = 37'd91625968982;

   localparam logic [DIST_BITS-1:0] CELL_SIZE_RESET = 32'd65536;

   localparam logic [1:0] COUNT_NONE  = 2'd0;
   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_KNOWN = 1'b1;

   typedef struct packed {
      logic [1:0]           count;
      logic                 neg;
      logic                 short_hit;
      logic [DIST_BITS:0]   short_val;
      logic [DIST_BITS:0]   sum2;
      logic [SUM3_BITS-1:0] sum3;
      logic [DIST_BITS:0]   base1;
   } ctl_type;

endpackage

@@ src/eku_prep.sv @@
// Front end: per-axis minimum, compaction of known axes, pair selection.
// Depends on eku_pkg.
module eku_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  logic [6*eku_pkg::DIST_BITS-1:0] in_values,
   input  logic [5:0]                    in_known,
   input  logic [eku_pkg::DIST_BITS-1:0] dx,
   output logic                          out_valid,
   output eku_pkg::ctl_type              out_ctl,
   output logic [eku_pkg::DIST_BITS-1:0] out_p,
   output logic [eku_pkg::DIST_BITS-1:0] out_q,
   output logic [eku_pkg::DIST_BITS-1:0] out_r,
   output logic [eku_pkg::DIST_BITS-1:0] out_d
);
   localparam int DW = eku_pkg::DIST_BITS;

   logic [DW-1:0] v_in [3];
   logic [DW-1:0] v_ff [3];
   logic [1:0]    count_in, count_ff;
   logic          vld1_ff;

   always_comb begin
      logic [1:0]    cnt;
      logic [DW-1:0] lo, hi;
      cnt = 2'd0;
      for (int i = 0; i < 3; i++) v_in[i] = '0;
      for (int ax = 0; ax < 3; ax++) begin
         lo = in_values[2*ax*DW +: DW];
         hi = in_values[(2*ax+1)*DW +: DW];
         if (in_known[2*ax] || in_known[2*ax+1]) begin
            if (in_known[2*ax] && in_known[2*ax+1]) v_in[cnt] = (lo < hi) ? lo : hi;
            else if (in_known[2*ax]) v_in[cnt] = lo;
            else v_in[cnt] = hi;
            cnt = cnt + 2'd1;
         end
      end
      count_in = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (ce) begin
         vld1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         count_ff <= count_in;
         for (int i = 0; i < 3; i++) v_ff[i] <= v_in[i];
      end
   end

   // Second stage: the pair for the two-value solve. With three axes it is
   // the fallback pair, the largest value dropped (first one on a tie).
   logic [DW-1:0]  p, q;
   logic [DW:0]    p_dx, q_dx;
   eku_pkg::ctl_type ctl_in, ctl_ff;
   logic [DW-1:0]  d_in, d_ff;
   logic [DW-1:0]  p_ff, q_ff, r_ff;
   logic           vld2_ff;

   always_comb begin
      logic [1:0]    idx;
      logic [DW-1:0] m;
      idx = 2'd0;
      m   = v_ff[0];
      if (v_ff[1] > m) begin
         idx = 2'd1;
         m   = v_ff[1];
      end
      if (v_ff[2] > m) idx = 2'd2;
      p = v_ff[0];
      q = v_ff[1];
      if (count_ff == eku_pkg::COUNT_THREE) begin
         case (idx)
            2'd0: begin
               p = v_ff[1];
               q = v_ff[2];
            end
            2'd1: begin
               p = v_ff[0];
               q = v_ff[2];
            end
            default: begin
               p = v_ff[0];
               q = v_ff[1];
            end
         endcase
      end
      p_dx = {1'b0, p} + {1'b0, dx};
      q_dx = {1'b0, q} + {1'b0, dx};
      d_in = (p > q) ? (p - q) : (q - p);
      ctl_in.count     = count_ff;
      ctl_in.neg       = 1'b0;
      ctl_in.short_hit = ({1'b0, p} >= q_dx) || ({1'b0, q} >= p_dx);
      ctl_in.short_val = ({1'b0, p} >= q_dx) ? q_dx : p_dx;
      ctl_in.sum2      = {1'b0, p} + {1'b0, q};
      ctl_in.sum3      = {2'b00, v_ff[0]} + {2'b00, v_ff[1]} + {2'b00, v_ff[2]};
      ctl_in.base1     = {1'b0, v_ff[0]} + {1'b0, dx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (ce) begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ctl_ff <= ctl_in;
         d_ff   <= d_in;
         p_ff   <= v_ff[0];
         q_ff   <= v_ff[1];
         r_ff   <= v_ff[2];
      end
   end

   assign out_valid = vld2_ff;
   assign out_ctl   = ctl_ff;
   assign out_p     = p_ff;
   assign out_q     = q_ff;
   assign out_r     = r_ff;
   assign out_d     = d_ff;
endmodule

@@ src/eku_square.sv @@
// Squares and discriminants of the two- and three-value solves.
// Depends on eku_pkg.
module eku_square (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  eku_pkg::ctl_type              in_ctl,
   input  logic [eku_pkg::DIST_BITS-1:0] in_p,
   input  logic [eku_pkg::DIST_BITS-1:0] in_q,
   input  logic [eku_pkg::DIST_BITS-1:0] in_r,
   input  logic [eku_pkg::DIST_BITS-1:0] in_d,
   input  logic [eku_pkg::DIST_BITS-1:0] dx,
   output logic                          out_valid,
   output eku_pkg::ctl_type              out_ctl,
   output logic [eku_pkg::RAD_BITS-1:0]  out_rad
);
   localparam int PW = 2 * eku_pkg::DIST_BITS;
   localparam int RW = eku_pkg::RAD_BITS;
   localparam int AW = RW + 2;

   logic [PW-1:0] dd_ff, pp_ff, qq_ff, rr_ff, d2_ff;
   logic [RW-1:0] ss_ff;
   eku_pkg::ctl_type ctl3_ff, ctl4_ff, ctl5_ff;
   logic          vld3_ff, vld4_ff, vld5_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         dd_ff   <= dx * dx;
         pp_ff   <= in_p * in_p;
         qq_ff   <= in_q * in_q;
         rr_ff   <= in_r * in_r;
         d2_ff   <= in_d * in_d;
         ss_ff   <= in_ctl.sum3 * in_ctl.sum3;
         ctl3_ff <= in_ctl;
      end
   end

   logic [AW-1:0] a_in, b_in, a_ff, b_ff;
   logic [RW-1:0] delta2_in, delta2_ff;

   always_comb begin
      logic [AW-1:0] dd_w, sq_w;
      dd_w      = AW'(dd_ff);
      sq_w      = AW'(pp_ff) + AW'(qq_ff) + AW'(rr_ff);
      a_in      = AW'(ss_ff) + dd_w + (dd_w << 1);
      b_in      = sq_w + (sq_w << 1);
      // Wraps only where the one-sided shortcut applies and the root is unused.
      delta2_in = RW'((AW'(dd_ff) << 1) - AW'(d2_ff));
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         delta2_ff <= delta2_in;
         ctl4_ff   <= ctl3_ff;
      end
   end

   logic          neg;
   logic [RW-1:0] rad_in, rad_ff;
   eku_pkg::ctl_type ctl5_in;

   always_comb begin
      neg     = a_ff < b_ff;
      ctl5_in = ctl4_ff;
      ctl5_in.neg = neg;
      if (ctl4_ff.count == eku_pkg::COUNT_THREE && !neg) rad_in = RW'(a_ff - b_ff);
      else rad_in = delta2_ff;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rad_ff  <= rad_in;
         ctl5_ff <= ctl5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else if (ce) begin
         vld3_ff <= in_valid;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
   end

   assign out_valid = vld5_ff;
   assign out_ctl   = ctl5_ff;
   assign out_rad   = rad_ff;
endmodule

@@ src/eku_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, rounding down.
// Depends on eku_pkg.
module eku_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           ce,
   input  logic                           in_valid,
   input  eku_pkg::ctl_type               in_ctl,
   input  logic [eku_pkg::RAD_BITS-1:0]   in_rad,
   output logic                           out_valid,
   output eku_pkg::ctl_type               out_ctl,
   output logic [eku_pkg::ROOT_BITS-1:0]  out_root
);
   localparam int RW = eku_pkg::RAD_BITS;
   localparam int NS = eku_pkg::ROOT_BITS;

   logic [RW-1:0]    num_ff [NS];
   logic [RW-1:0]    res_ff [NS];
   eku_pkg::ctl_type ctl_ff [NS];
   logic [NS-1:0]    vld_ff;

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NS - 1 - k));
      logic [RW-1:0]    num_src, res_src, trial, num_in, res_in;
      eku_pkg::ctl_type ctl_src;
      logic             vld_src;

      if (k == 0) begin : g_first
         assign num_src = in_rad;
         assign res_src = '0;
         assign ctl_src = in_ctl;
         assign vld_src = in_valid;
      end else begin : g_next
         assign num_src = num_ff[k-1];
         assign res_src = res_ff[k-1];
         assign ctl_src = ctl_ff[k-1];
         assign vld_src = vld_ff[k-1];
      end

      always_comb begin
         trial = res_src + BIT;
         if (num_src >= trial) begin
            num_in = num_src - trial;
            res_in = (res_src >> 1) + BIT;
         end else begin
            num_in = num_src;
            res_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            num_ff[k] <= num_in;
            res_ff[k] <= res_in;
            ctl_ff[k] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ce) begin
            vld_ff[k] <= vld_src;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_ctl   = ctl_ff[NS-1];
   assign out_root  = res_ff[NS-1][NS-1:0];
endmodule

@@ src/eku_finish.sv @@
// Back end: final sum, halving or division by three, selection, saturation.
// Depends on eku_pkg. Its last stage is the output register.
module eku_finish (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  eku_pkg::ctl_type              in_ctl,
   input  logic [eku_pkg::ROOT_BITS-1:0] in_root,
   output logic                          out_valid,
   output logic [eku_pkg::DIST_BITS-1:0] out_distance,
   output logic                          out_status
);
   localparam int DW = eku_pkg::DIST_BITS;
   localparam int TW = eku_pkg::TOT_BITS;
   localparam int HW = eku_pkg::HALF_BITS;
   localparam int MW = eku_pkg::DIV3_BITS;
   localparam int PW = HW + MW;
   localparam int QW = PW + HW;

   logic             sel3_in, sel3_ff, sel3b_ff;
   logic [TW-1:0]    tot_in, tot_ff;
   eku_pkg::ctl_type ctl1_ff, ctl2_ff;
   logic             vld1_ff, vld2_ff;

   always_comb begin
      sel3_in = (in_ctl.count == eku_pkg::COUNT_THREE) && !in_ctl.neg;
      if (sel3_in) tot_in = TW'(in_ctl.sum3) + TW'(in_root);
      else tot_in = TW'(in_ctl.sum2) + TW'(in_root);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         tot_ff  <= tot_in;
         sel3_ff <= sel3_in;
         ctl1_ff <= in_ctl;
      end
   end

   // Two partial products of the reciprocal multiply.
   logic [PW-1:0] ph_ff, pl_ff;
   logic [TW-2:0] half_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         ph_ff    <= tot_ff[TW-1:HW] * eku_pkg::DIV3_MUL;
         pl_ff    <= tot_ff[HW-1:0] * eku_pkg::DIV3_MUL;
         half_ff  <= tot_ff[TW-1:1];
         sel3b_ff <= sel3_ff;
         ctl2_ff  <= ctl1_ff;
      end
   end

   logic [QW-1:0]   prod;
   logic [TW-1:0]   pick;
   logic [DW-1:0]   dist_in, dist_ff;
   logic            status_in, status_ff;
   logic            vld3_ff;

   always_comb begin
      prod = (QW'(ph_ff) << HW) + QW'(pl_ff);
      if (sel3b_ff) pick = TW'(prod >> eku_pkg::DIV3_SHIFT);
      else if (ctl2_ff.short_hit) pick = TW'(ctl2_ff.short_val);
      else pick = TW'(half_ff);
      if (ctl2_ff.count == eku_pkg::COUNT_ONE) pick = TW'(ctl2_ff.base1);
      status_in = eku_pkg::STATUS_OK;
      if (ctl2_ff.count == eku_pkg::COUNT_NONE) begin
         dist_in   = '0;
         status_in = eku_pkg::STATUS_NO_KNOWN;
      end else if (pick[TW-1:DW] != '0) begin
         dist_in = '1;
      end else begin
         dist_in = pick[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dist_ff   <= dist_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (ce) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   assign out_valid    = vld3_ff;
   assign out_distance = dist_ff;
   assign out_status   = status_ff;
endmodule

@@ src/eikonal_cell_update.sv @@
// Eikonal cell update: a request runs through eku_prep, eku_square, eku_sqrt, eku_finish.
// Throughput is one request per cycle unless stalled; the 34-stage sqrt sets the depth.
// The whole pipeline advances together and holds while a result waits to be taken.
// Reset is synchronous and active high; it empties the pipeline and sets the cell
// size to 1.0. Depends on eku_pkg, eku_* stages, eikonal_cell_update_assert.svh.
`include "eikonal_cell_update_assert.svh"

module eikonal_cell_update (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // xm_value, xp_value, ym_value, yp_value, zm_value, zp_value, from bit 0 up
   input  logic [191:0] req_tdata,
   // xm_known, xp_known, ym_known, yp_known, zm_known, zp_known, from bit 0 up
   input  logic [5:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance
   output logic [31:0]  rsp_tdata,
   // status
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);
   logic [31:0] cell_size_ff;
   logic        ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= eku_pkg::CELL_SIZE_RESET;
      end else if (csr_valid) begin
         cell_size_ff <= csr_data;
      end
   end

   assign csr_ready  = 1'b1;
   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   eku_pkg::ctl_type ctl_a, ctl_b, ctl_c;
   logic            vld_a, vld_b, vld_c;
   logic [31:0]     p_a, q_a, r_a, d_a;
   logic [eku_pkg::RAD_BITS-1:0]  rad_b;
   logic [eku_pkg::ROOT_BITS-1:0] root_c;

   eku_prep u_prep (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(req_tvalid && req_tready), .in_values(req_tdata), .in_known(req_tuser),
      .dx(cell_size_ff), .out_valid(vld_a), .out_ctl(ctl_a),
      .out_p(p_a), .out_q(q_a), .out_r(r_a), .out_d(d_a)
   );

   eku_square u_square (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(vld_a), .in_ctl(ctl_a), .in_p(p_a), .in_q(q_a), .in_r(r_a), .in_d(d_a),
      .dx(cell_size_ff), .out_valid(vld_b), .out_ctl(ctl_b), .out_rad(rad_b)
   );

   eku_sqrt u_sqrt (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(vld_b), .in_ctl(ctl_b), .in_rad(rad_b),
      .out_valid(vld_c), .out_ctl(ctl_c), .out_root(root_c)
   );

   eku_finish u_finish (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(vld_c), .in_ctl(ctl_c), .in_root(root_c),
      .out_valid(rsp_tvalid), .out_distance(rsp_tdata), .out_status(rsp_tuser[0])
   );

   // A request with no known neighbour reports a zero distance.
   `EKU_ASSERT_NOW(a_error_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == 32'd0)
   // The entry only closes while a result is waiting.
   `EKU_ASSERT_NOW(a_stall_cause, !req_tready, rsp_tvalid && !rsp_tready)
   // Nothing leaves the pipeline in the cycle after reset.
   `EKU_ASSERT_NEXT(a_empty_after_reset, $rose(reset) || reset, !rsp_tvalid || !$past(reset))
endmodule

@@ tb/sv/eikonal_cell_update_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of eikonal_cell_update: directed table, then random
// neighbour sets over several cell sizes and idling phases. Depends on eku_pkg.
module eikonal_cell_update_tb;

   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 5000;
   localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

   typedef struct {
      logic [31:0] distance;
      logic        status;
   } update_type;

   typedef struct {
      logic [191:0] values;
      logic [5:0]   known;
      bit           typed;
      update_type   want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic [5:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;

   logic [31:0]  cell_dx = eku_pkg::CELL_SIZE_RESET;
   update_type   pending_updates[$];
   stim_row_type table_rows[$];
   bit           typed_flags[$];
   update_type   typed_wants[$];
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           errors = 0;
   int           quiet_cycles = 0;

   eikonal_cell_update dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(logic [127:0] n);
      logic [63:0]  root;
      logic [63:0]  trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if ({64'd0, trial} * {64'd0, trial} <= n) root = trial;
      end
      return root;
   endfunction

   function automatic logic [63:0] upwind_two(logic [63:0] p, logic [63:0] q,
                                              logic [63:0] dx);
      logic [63:0]  diff;
      logic [127:0] disc;
      if (p >= q + dx) return q + dx;
      if (q >= p + dx) return p + dx;
      diff = (p > q) ? p - q : q - p;
      disc = 2 * ({64'd0, dx} * dx) - {64'd0, diff} * diff;
      return (p + q + int_sqrt(disc)) >> 1;
   endfunction

   function automatic logic [63:0] upwind_three(logic [63:0] p, logic [63:0] q,
                                                logic [63:0] r, logic [63:0] dx);
      logic [63:0]  s;
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] total;
      s   = p + q + r;
      lhs = {64'd0, s} * s + 3 * ({64'd0, dx} * dx);
      rhs = 3 * ({64'd0, p} * p + {64'd0, q} * q + {64'd0, r} * r);
      if (lhs < rhs) begin
         // Drop the largest value; the earliest axis wins a tie.
         if (p >= q && p >= r) return upwind_two(q, r, dx);
         if (q > p && q >= r) return upwind_two(p, r, dx);
         return upwind_two(p, q, dx);
      end
      total = s + int_sqrt(lhs - rhs);
      return 64'(total / 3);
   endfunction

   function automatic update_type predict_update(logic [191:0] values, logic [5:0] known);
      logic [63:0] axis_min[3];
      logic [63:0] lo_v;
      logic [63:0] hi_v;
      logic [63:0] res;
      int          n;
      update_type  u;
      n = 0;
      for (int ax = 0; ax < 3; ax++) begin
         lo_v = 64'(values[64*ax +: 32]);
         hi_v = 64'(values[64*ax+32 +: 32]);
         if (known[2*ax] && known[2*ax+1]) axis_min[n++] = (lo_v < hi_v) ? lo_v : hi_v;
         else if (known[2*ax]) axis_min[n++] = lo_v;
         else if (known[2*ax+1]) axis_min[n++] = hi_v;
      end
      if (n == 0) begin
         u.distance = '0;
         u.status   = eku_pkg::STATUS_NO_KNOWN;
         return u;
      end
      if (n == 1) res = axis_min[0] + 64'(cell_dx);
      else if (n == 2) res = upwind_two(axis_min[0], axis_min[1], 64'(cell_dx));
      else res = upwind_three(axis_min[0], axis_min[1], axis_min[2], 64'(cell_dx));
      u.distance = (res > 64'(DIST_MAX)) ? DIST_MAX : res[31:0];
      u.status   = eku_pkg::STATUS_OK;
      return u;
   endfunction

   // Expectations are formed from the request accepted at this edge.
   always @(posedge clock) begin
      update_type u;
      update_type w;
      bit         typed;
      if (!reset && req_tvalid && req_tready) begin
         u = predict_update(req_tdata, req_tuser);
         if (typed_flags.size() > 0) begin
            typed = typed_flags.pop_front();
            w     = typed_wants.pop_front();
            if (typed) u = w;
         end
         pending_updates.push_back(u);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected result distance=%h status=%b",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            u = pending_updates.pop_front();
            if (rsp_tdata !== u.distance) begin
               $display("%0t: distance expected %h actual %h", $time, u.distance, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[0] !== u.status) begin
               $display("%0t: status expected %b actual %b", $time, u.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(logic [191:0] values, logic [5:0] known);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= values;
      req_tuser  <= known;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_updates.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cell_size(logic [31:0] dx);
      csr_valid <= 1'b1;
      csr_data  <= dx;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cell_dx = dx;
   endtask

   task automatic add_row(logic [31:0] xm, logic [31:0] xp, logic [31:0] ym,
                          logic [31:0] yp, logic [31:0] zm, logic [31:0] zp,
                          logic [5:0] known, bit typed, logic [31:0] want_dist,
                          logic st);
      stim_row_type row;
      row.values        = {zp, zm, yp, ym, xp, xm};
      row.known         = known;
      row.typed         = typed;
      row.want.distance = want_dist;
      row.want.status   = st;
      table_rows.push_back(row);
   endtask

   function automatic logic [31:0] near_value(logic [31:0] base, logic [31:0] spread);
      return base + $urandom_range(spread, 0);
   endfunction

   task automatic random_request();
      logic [31:0] v[6];
      logic [31:0] base;
      logic [31:0] spread;
      int          mode;
      mode = $urandom_range(9);
      if (mode == 0) begin
         foreach (v[i]) v[i] = $urandom;
      end else if (mode == 1) begin
         foreach (v[i]) v[i] = $urandom_range(1) ? DIST_MAX : 32'd0;
      end else begin
         // Neighbours within about one cell of each other reach the quadratic solves.
         base   = $urandom >> $urandom_range(16);
         spread = (cell_dx == 0) ? 32'd4 : (cell_dx >> $urandom_range(2)) + 32'd1;
         foreach (v[i]) v[i] = near_value(base, spread);
      end
      send_request({v[5], v[4], v[3], v[2], v[1], v[0]},
                   $urandom_range(3) == 0 ? 6'h3F : 6'($urandom));
   endtask

   initial begin
      logic [31:0] dx_list[8];
      dx_list = '{32'd1, DIST_MAX, 32'd0, 32'h8000, 32'h30000, 32'd65536, 32'd0, 32'd0};
      dx_list[6] = $urandom;
      dx_list[7] = $urandom_range(32'h40000, 32'd2);

      add_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 6'h00,
              1, 32'd0, eku_pkg::STATUS_NO_KNOWN);
      add_row(0, 0, 0, 0, 0, 0, 6'h01, 1, 32'd65536, eku_pkg::STATUS_OK);
      add_row(0, DIST_MAX, 0, 0, 0, 0, 6'h02, 1, DIST_MAX, eku_pkg::STATUS_OK);
      add_row(5, 3, 0, 0, 0, 0, 6'h03, 1, 32'd65539, eku_pkg::STATUS_OK);
      add_row(32'h20000, 0, 0, 0, 0, 0, 6'h05, 1, 32'd65536, eku_pkg::STATUS_OK);
      add_row(0, 0, 0, 0, 0, 0, 6'h14, 0, 0, eku_pkg::STATUS_OK);
      add_row(0, 0, 0, 0, 0, 0, 6'h3F, 0, 0, eku_pkg::STATUS_OK);
      add_row(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, 6'h3F,
              1, DIST_MAX, eku_pkg::STATUS_OK);
      add_row(0, 7, 0, 9, 32'h18000, 32'h18000, 6'h15, 0, 0, eku_pkg::STATUS_OK);
      add_row(32'h10000, 0, 32'h10000, 0, 0, 0, 6'h15, 0, 0, eku_pkg::STATUS_OK);
      add_row(0, 0, 32'h8000, 0, 32'h9000, 32'h4000, 6'h34, 0, 0, eku_pkg::STATUS_OK);
      add_row(32'h1000, 32'h2000, 32'h3000, 32'h800, 32'h4000, 32'h4100, 6'h3F,
              0, 0, eku_pkg::STATUS_OK);
      add_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 6'h2A,
              0, 0, eku_pkg::STATUS_OK);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) begin
         typed_flags.push_back(table_rows[i].typed);
         typed_wants.push_back(table_rows[i].want);
         send_request(table_rows[i].values, table_rows[i].known);
      end
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         write_cell_size(dx_list[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         for (int k = 0; k < 205; k++) begin
            if (ph == 1 && k == 100) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending_updates.size() > 0) @(posedge clock);
            end
            random_request();
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+src
src/eku_pkg.sv
src/eku_prep.sv
src/eku_square.sv
src/eku_sqrt.sv
src/eku_finish.sv
src/eikonal_cell_update.sv
tb/sv/eikonal_cell_update_tb.sv
